### rtl/core/owm_pkg.sv
package owm_pkg;

   localparam int CfgWidth = 10;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_RESET = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_READ  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_RESET_LOW      = 3'd0,
      CSR_PRESENCE_WAIT  = 3'd1,
      CSR_RESET_TAIL     = 3'd2,
      CSR_SHORT_LOW      = 3'd3,
      CSR_LONG_LOW       = 3'd4,
      CSR_READ_SAMPLE    = 3'd5,
      CSR_READ_RECOVER   = 3'd6,
      CSR_UNUSED         = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_RST_LOW   = 3'd1,
      PH_RST_WAIT  = 3'd2,
      PH_RST_TAIL  = 3'd3,
      PH_SLOT_LOW  = 3'd4,
      PH_SLOT_WAIT = 3'd5,
      PH_SLOT_REC  = 3'd6
   } phase_type;

   localparam logic [CfgWidth-1:0] ResetLowDefault      = 10'd480;
   localparam logic [CfgWidth-1:0] PresenceWaitDefault  = 10'd77;
   localparam logic [CfgWidth-1:0] ResetTailDefault     = 10'd97;
   localparam logic [CfgWidth-1:0] ShortLowDefault      = 10'd5;
   localparam logic [CfgWidth-1:0] LongLowDefault       = 10'd63;
   localparam logic [CfgWidth-1:0] ReadSampleDefault    = 10'd5;
   localparam logic [CfgWidth-1:0] ReadRecoverDefault   = 10'd58;

   localparam logic [2:0] LastBit = 3'd7;

   typedef struct packed {
      logic [CfgWidth-1:0] reset_low;
      logic [CfgWidth-1:0] presence_wait;
      logic [CfgWidth-1:0] reset_tail;
      logic [CfgWidth-1:0] short_low;
      logic [CfgWidth-1:0] long_low;
      logic [CfgWidth-1:0] read_sample;
      logic [CfgWidth-1:0] read_recover;
   } cfg_type;

   // first member sits in the top bits; drive_first_low is bit 0
   typedef struct packed {
      logic       rejected;
      logic [7:0] read_data;
      logic       presence_found;
      logic       done_res;
      logic       busy_res;
      logic       drive_second_low;
      logic       drive_first_low;
   } res_type;

endpackage

### rtl/core/one_wire_bus_master.sv
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: req_type; tdata: channel, data_byte, line_high
// rsp      out  rsp_tvalid/rsp_tready  tdata: drive lows, busy, done, presence, read_data, rejected
// csr      in   csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// One transaction per clock while req_tready is high: each item updates the bus state
// in the cycle it is accepted and its result lands in the output register on the same edge.
// req_tready stays high while the output register is empty or being drained.
// Synchronous active-high reset restores the default timings and idles the bus.
module one_wire_bus_master import owm_pkg::*; #(
   parameter int TIMER_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // channel[0], data_byte[8:1], line_high[9], zero pad
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // drive_first_low[0], drive_second_low[1], busy_res[2],
                                    // done_res[3], presence_found[4], read_data[12:5],
                                    // rejected[13], zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [CfgWidth-1:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   res_type res, rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    req_accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_RESET_LOW:     cfg_in.reset_low     = csr_data;
            CSR_PRESENCE_WAIT: cfg_in.presence_wait = csr_data;
            CSR_RESET_TAIL:    cfg_in.reset_tail    = csr_data;
            CSR_SHORT_LOW:     cfg_in.short_low     = csr_data;
            CSR_LONG_LOW:      cfg_in.long_low      = csr_data;
            CSR_READ_SAMPLE:   cfg_in.read_sample   = csr_data;
            CSR_READ_RECOVER:  cfg_in.read_recover  = csr_data;
            default: begin
            end
         endcase
      end
   end

   owm_engine #(
      .TIMER_BITS(TIMER_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (req_accept),
      .req_type  (req_tuser),
      .channel   (req_tdata[0]),
      .data_byte (req_tdata[8:1]),
      .line_high (req_tdata[9]),
      .cfg       (cfg_ff),
      .res       (res)
   );

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low     <= ResetLowDefault;
         cfg_ff.presence_wait <= PresenceWaitDefault;
         cfg_ff.reset_tail    <= ResetTailDefault;
         cfg_ff.short_low     <= ShortLowDefault;
         cfg_ff.long_low      <= LongLowDefault;
         cfg_ff.read_sample   <= ReadSampleDefault;
         cfg_ff.read_recover  <= ReadRecoverDefault;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff};

   a_done_not_rejected: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_ff.done_res && rsp_ff.rejected))
      else $error("done and rejected in one transaction");

   a_one_line_driven: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_ff.drive_first_low && rsp_ff.drive_second_low))
      else $error("both lines driven low");

   a_drive_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_ff.drive_first_low || rsp_ff.drive_second_low))
      |-> rsp_ff.busy_res)
      else $error("line driven while idle");

   a_done_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.done_res) |-> !rsp_ff.busy_res)
      else $error("busy after completion");

endmodule

### rtl/core/owm_engine.sv
module owm_engine import owm_pkg::*; #(
   parameter int TIMER_BITS = 10
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [1:0]      req_type,
   input  logic            channel,
   input  logic [7:0]      data_byte,
   input  logic            line_high,
   input  cfg_type         cfg,
   output res_type         res
);

   localparam logic [TIMER_BITS-1:0] TickOne = TIMER_BITS'(1);

   function automatic logic [TIMER_BITS-1:0] load(input logic [CfgWidth-1:0] v);
      logic [CfgWidth+TIMER_BITS-1:0] wide;
      wide = {{TIMER_BITS{1'b0}}, v};
      return wide[TIMER_BITS-1:0];
   endfunction

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] tick_ff, tick_in;
   logic [2:0]            bit_ff, bit_in;
   logic [7:0]            shift_ff, shift_in;
   logic                  chan_ff, chan_in;
   logic                  presence_ff, presence_in;
   logic                  op_read_ff, op_read_in;
   logic [7:0]            last_read_ff, last_read_in;
   logic [7:0]            shift_rec;
   logic                  done, rej, low;

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      chan_in      = chan_ff;
      presence_in  = presence_ff;
      op_read_in   = op_read_ff;
      last_read_in = last_read_ff;
      done         = 1'b0;
      rej          = 1'b0;
      shift_rec    = op_read_ff ? shift_ff : {1'b0, shift_ff[7:1]};
      if (step) begin
         if (req_kind_type'(req_type) != REQ_TICK) begin
            if (phase_ff != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               chan_in    = channel;
               bit_in     = 3'd0;
               op_read_in = (req_kind_type'(req_type) == REQ_READ);
               if (req_kind_type'(req_type) == REQ_RESET) begin
                  phase_in = PH_RST_LOW;
                  tick_in  = load(cfg.reset_low);
               end else begin
                  shift_in = (req_kind_type'(req_type) == REQ_WRITE) ? data_byte : 8'd0;
                  phase_in = PH_SLOT_LOW;
                  tick_in  = (req_kind_type'(req_type) == REQ_READ || data_byte[0]) ?
                             load(cfg.short_low) : load(cfg.long_low);
               end
            end
         end else if (phase_ff != PH_IDLE) begin
            if (tick_ff > TickOne) begin
               tick_in = tick_ff - TickOne;
            end else begin
               case (phase_ff)
                  PH_RST_LOW: begin
                     phase_in = PH_RST_WAIT;
                     tick_in  = load(cfg.presence_wait);
                  end
                  PH_RST_WAIT: begin
                     presence_in = ~line_high;
                     phase_in    = PH_RST_TAIL;
                     tick_in     = load(cfg.reset_tail);
                  end
                  PH_RST_TAIL: begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
                  PH_SLOT_LOW: begin
                     if (op_read_ff) begin
                        phase_in = PH_SLOT_WAIT;
                        tick_in  = load(cfg.read_sample);
                     end else begin
                        phase_in = PH_SLOT_REC;
                        tick_in  = shift_ff[0] ? load(cfg.long_low) : load(cfg.short_low);
                     end
                  end
                  PH_SLOT_WAIT: begin
                     shift_in = {line_high, shift_ff[7:1]};
                     phase_in = PH_SLOT_REC;
                     tick_in  = load(cfg.read_recover);
                  end
                  PH_SLOT_REC: begin
                     shift_in = shift_rec;
                     if (bit_ff == LastBit) begin
                        if (op_read_ff) begin
                           last_read_in = shift_rec;
                        end
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        bit_in   = bit_ff + 3'd1;
                        phase_in = PH_SLOT_LOW;
                        tick_in  = (op_read_ff || shift_rec[0]) ?
                                   load(cfg.short_low) : load(cfg.long_low);
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      low                  = (phase_in == PH_RST_LOW) || (phase_in == PH_SLOT_LOW);
      res.drive_first_low  = low && !chan_in;
      res.drive_second_low = low && chan_in;
      res.busy_res         = (phase_in != PH_IDLE);
      res.done_res         = done;
      res.presence_found   = presence_in;
      res.read_data        = last_read_in;
      res.rejected         = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         chan_ff      <= 1'b0;
         presence_ff  <= 1'b0;
         op_read_ff   <= 1'b0;
         last_read_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         chan_ff      <= chan_in;
         presence_ff  <= presence_in;
         op_read_ff   <= op_read_in;
         last_read_ff <= last_read_in;
      end
   end

endmodule
